// ----- rtl/i2a_pkg.sv -----
package i2a_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned DIGITS   = 10;
    localparam int unsigned BCD_W    = 4 * DIGITS;
    localparam int unsigned REM_W    = 4;

    localparam logic [1:0] MODE_DEC  = 2'd0;
    localparam logic [1:0] MODE_HEX2 = 2'd1;
    localparam logic [1:0] MODE_HEX4 = 2'd2;
    localparam logic [1:0] MODE_HEX8 = 2'd3;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_X    = 8'h78;

    localparam logic [7:0] HEX_GLYPHS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    typedef struct packed {
        logic [1:0]         mode;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/integer_to_ascii_converter.sv -----
// Sequencing: hex words emit a 0x prefix, then their digits; decimal words first
// pass the double-dabble unit, drop leading zeros one at a time and leave the skip,
// then one char per cycle while rsp_stall is low (zeros plus digits is ten).
// A new word is accepted only once the last char of the current one is emitted.
// Reset: rst_n asynchronous, clears the sequencer and output valid.
module integer_to_ascii_converter
    import i2a_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t            state_reg, state_next;
    logic [BCD_W-1:0]  sh_reg, sh_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [1:0]        pfx_reg, pfx_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    logic              bcd_start;
    logic              bcd_done;
    logic [BCD_W-1:0]  bcd;
    logic              load;
    logic              last_char;

    i2a_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .bin   (req.value),
        .done  (bcd_done),
        .bcd   (bcd)
    );

    assign load      = !rsp_valid_reg || !rsp_stall;
    assign last_char = (pfx_reg == 2'd0) && (rem_reg == REM_W'(1));

    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        rem_next       = rem_reg;
        pfx_next       = pfx_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        bcd_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    pfx_next = 2'd2;
                    case (req.mode)
                        MODE_DEC:
                        begin
                            bcd_start  = 1'b1;
                            pfx_next   = 2'd0;
                            state_next = ST_CONV;
                        end
                        MODE_HEX2:
                        begin
                            sh_next    = {req.value[7:0], (BCD_W-8)'(0)};
                            rem_next   = REM_W'(2);
                            state_next = ST_EMIT;
                        end
                        MODE_HEX4:
                        begin
                            sh_next    = {req.value[15:0], (BCD_W-16)'(0)};
                            rem_next   = REM_W'(4);
                            state_next = ST_EMIT;
                        end
                        default:
                        begin
                            sh_next    = {req.value, (BCD_W-VALUE_W)'(0)};
                            rem_next   = REM_W'(8);
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (bcd_done)
                begin
                    sh_next    = bcd;
                    rem_next   = REM_W'(DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zero digits, keep at least one
                if ((sh_reg[BCD_W-1 -: 4] == 4'd0) && (rem_reg > REM_W'(1)))
                begin
                    sh_next  = {sh_reg[BCD_W-5:0], 4'd0};
                    rem_next = rem_reg - 1'b1;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next.last  = last_char;
                    case (pfx_reg)
                        2'd2:    rsp_next.char_code = CHAR_ZERO;
                        2'd1:    rsp_next.char_code = CHAR_X;
                        default: rsp_next.char_code = HEX_GLYPHS[sh_reg[BCD_W-1 -: 4]];
                    endcase
                    if (pfx_reg != 2'd0)
                        pfx_next = pfx_reg - 1'b1;
                    else
                    begin
                        sh_next  = {sh_reg[BCD_W-5:0], 4'd0};
                        rem_next = rem_reg - 1'b1;
                    end
                    if (last_char)
                        state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rem_reg       <= '0;
            pfx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rem_reg       <= rem_next;
            pfx_reg       <= pfx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    a_mid_word_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.last |-> state_reg == ST_EMIT)
        else $error("non-final char pending while sequencer idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != ST_IDLE)
        else $error("accepted word did not start conversion");

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && pfx_reg == 2'd0 |-> rem_reg != '0)
        else $error("emit with no digits left");

    a_skip_keeps_one: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SKIP |-> rem_reg >= REM_W'(1))
        else $error("leading zero skip dropped every digit");
`endif

endmodule

// ----- rtl/i2a_bcd.sv -----
// Double-dabble: one add-3 and shift step per cycle, VALUE_W steps per word.
module i2a_bcd
    import i2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [VALUE_W-1:0] bin,
    output logic               done,
    output logic [BCD_W-1:0]   bcd
);

    localparam int unsigned CNT_W = $clog2(VALUE_W + 1);

    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic [BCD_W-1:0]   adj;

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            bin_next  = bin;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
            begin
                bcd_next = {adj[BCD_W-2:0], bin_reg[VALUE_W-1]};
                bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign bcd  = bcd_reg;

endmodule
